[src/kbsf_pkg.sv]
// ----------------------------------------------------------------------------
// kbsf_pkg
// Shared types and constants of the keyed byte scrambler frame unit.
// ----------------------------------------------------------------------------
package kbsf_pkg;

  localparam int FRAME_LIMIT_DEFAULT = 140;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CR_BYTE = 8'h0d;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  localparam logic [1:0] REG_SCRAMBLE_ENABLE = 2'd0;
  localparam logic [1:0] REG_KEY_LOW         = 2'd1;
  localparam logic [1:0] REG_KEY_HIGH        = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_checksum;
    logic       last;
    logic [7:0] frame_length;
  } result_t;

  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } job_t;

endpackage

[src/kbsf_front.sv]
// ----------------------------------------------------------------------------
// kbsf_front
// Accepts items and configuration writes, keeps the frame state and turns
// each accepted item into a job of one or two results for the output queue, or into none.
// ----------------------------------------------------------------------------
module kbsf_front
  import kbsf_pkg::*;
#(
  parameter int FRAME_LIMIT = FRAME_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        queue_full,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        in_stall,
  output logic        push,
  output job_t        job
);

  localparam logic [7:0] LIMIT = 8'(FRAME_LIMIT);

  logic        scramble_enable;
  logic [63:0] key_low;
  logic [63:0] key_high;
  logic        in_frame;
  logic [3:0]  key_index;
  logic [7:0]  running_checksum;
  logic [7:0]  sent_count;

  logic        in_frame_next;
  logic [3:0]  key_index_next;
  logic [7:0]  running_checksum_next;
  logic [7:0]  sent_count_next;

  logic         accept;
  logic [127:0] key_all;
  logic [7:0]   key_byte;
  logic [7:0]   mixed;
  logic [7:0]   scrambled;
  logic [7:0]   count_inc;
  logic         at_limit;
  logic         is_cr;

  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;
  assign key_all   = {key_high, key_low};
  assign key_byte  = key_all[{key_index, 3'b000} +: 8];
  assign mixed     = data_byte ^ key_byte;
  assign scrambled = {mixed[1:0], mixed[7:2]} ^ key_byte;
  assign count_inc = sent_count + 8'd1;
  assign at_limit  = count_inc >= LIMIT;
  assign is_cr     = data_byte == CR_BYTE;

  always_comb begin
    in_frame_next         = in_frame;
    key_index_next        = key_index;
    running_checksum_next = running_checksum;
    sent_count_next       = sent_count;
    push                  = 1'b0;
    job                   = '0;
    if (accept) begin
      if (kind == KIND_START) begin
        in_frame_next = 1'b1;
        if (scramble_enable) begin
          running_checksum_next = data_byte;
          key_index_next        = data_byte[7:4] + data_byte[3:0];
          sent_count_next       = 8'd1;
          push                  = 1'b1;
          job.first             = '{data_byte, 1'b0, 1'b0, 8'd1};
        end else begin
          running_checksum_next = 8'd0;
          key_index_next        = 4'd0;
          sent_count_next       = 8'd0;
        end
      end else if (in_frame) begin
        push = 1'b1;
        if (scramble_enable) begin
          if (is_cr) begin
            in_frame_next = 1'b0;
            job.first     = '{running_checksum, 1'b1, 1'b1, count_inc};
          end else begin
            key_index_next        = key_index + 4'd1;
            running_checksum_next = running_checksum ^ scrambled;
            sent_count_next       = count_inc;
            job.first             = '{scrambled, 1'b0, 1'b0, count_inc};
            if (at_limit) begin
              in_frame_next = 1'b0;
              job.two       = 1'b1;
              job.second    = '{running_checksum ^ scrambled, 1'b1, 1'b1,
                                count_inc + 8'd1};
            end
          end
        end else begin
          sent_count_next = count_inc;
          if (is_cr || at_limit) begin
            in_frame_next = 1'b0;
          end
          job.first = '{data_byte, 1'b0, is_cr || at_limit, count_inc};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scramble_enable  <= 1'b0;
      key_low          <= '0;
      key_high         <= '0;
      in_frame         <= 1'b0;
      key_index        <= '0;
      running_checksum <= '0;
      sent_count       <= '0;
    end else begin
      in_frame         <= in_frame_next;
      key_index        <= key_index_next;
      running_checksum <= running_checksum_next;
      sent_count       <= sent_count_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_SCRAMBLE_ENABLE: scramble_enable <= cfg_data[0];
          REG_KEY_LOW:         key_low         <= cfg_data;
          REG_KEY_HIGH:        key_high        <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[src/kbsf_queue.sv]
// ----------------------------------------------------------------------------
// kbsf_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module kbsf_queue
  import kbsf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[src/kbsf_back.sv]
// ----------------------------------------------------------------------------
// kbsf_back
// Takes jobs from the queue and delivers their results one per cycle,
// while the output is not stalled, through the output register.
// ----------------------------------------------------------------------------
module kbsf_back
  import kbsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       empty,
  input  logic       out_stall,
  output logic       pop,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       is_checksum,
  output logic       last,
  output logic [7:0] frame_length
);

  result_t out_reg;
  result_t second;
  logic    second_pend;
  logic    load;

  assign load         = !out_valid || !out_stall;
  assign pop          = load && !second_pend && !empty;
  assign out_byte     = out_reg.out_byte;
  assign is_checksum  = out_reg.is_checksum;
  assign last         = out_reg.last;
  assign frame_length = out_reg.frame_length;

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_pend) begin
        out_reg <= second;
      end else begin
        out_reg <= head.first;
        second  <= head.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      second_pend <= 1'b0;
    end else if (load) begin
      if (second_pend) begin
        out_valid   <= 1'b1;
        second_pend <= 1'b0;
      end else begin
        out_valid   <= !empty;
        second_pend <= !empty && head.two;
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_has_output: assert property (@(posedge clk) disable iff (rst)
    second_pend |-> out_valid)
    else $error("Second result pending without a result on the output.");

  a_pend_is_checksum: assert property (@(posedge clk) disable iff (rst)
    second_pend |-> (second.is_checksum && second.last))
    else $error("Pending second result is not the closing checksum.");

  a_checksum_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_checksum) |-> last)
    else $error("Checksum result not marked as the last of its frame.");

  a_no_pop_while_pend: assert property (@(posedge clk) disable iff (rst)
    second_pend |-> !pop)
    else $error("Queue popped while a second result was still pending.");
`endif

endmodule

[src/keyed_byte_scrambler_frame_unit.sv]
// ----------------------------------------------------------------------------
// keyed_byte_scrambler_frame_unit
// Keyed byte scrambler for message frames, with trailing XOR checksum.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock cycle as long as its job queue has
// room, and an item's first result reaches the output through the job
// queue and then the output register. Each item yields at most one result
// per cycle on the output, except the byte that reaches the frame limit
// while scrambling, which yields two, delivered one after the other. The queue
// (QUEUE_DEPTH jobs) absorbs those second results and output stalls; in_stall
// rises only when it is full. Configuration writes are always taken
// (cfg_ready is tied high) and must be made while the unit is idle.
module keyed_byte_scrambler_frame_unit
  import kbsf_pkg::*;
#(
  parameter int FRAME_LIMIT = FRAME_LIMIT_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_checksum,
  output logic        last,
  output logic [7:0]  frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t new_job;
  job_t head;

  assign cfg_ready = 1'b1;

  kbsf_front #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .queue_full(full),
    .kind      (kind),
    .data_byte (data_byte),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_stall  (in_stall),
    .push      (push),
    .job       (new_job)
  );

  kbsf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_job(new_job),
    .pop   (pop),
    .head  (head),
    .full  (full),
    .empty (empty)
  );

  kbsf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .out_stall   (out_stall),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .is_checksum (is_checksum),
    .last        (last),
    .frame_length(frame_length)
  );

endmodule

[verif/tb_keyed_byte_scrambler_frame_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_byte_scrambler_frame_unit
// Self-checking bench for the keyed byte scrambler frame unit. Frames of seed
// and message bytes are fed under several key and enable settings and idle
// patterns, and every link byte is checked against a scrambler model kept
// here.
// ----------------------------------------------------------------------------
module tb_keyed_byte_scrambler_frame_unit;
  import kbsf_pkg::*;

  localparam int LIMIT       = FRAME_LIMIT_DEFAULT;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN       = 16;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } feed_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = KIND_START;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        is_checksum;
  logic        last;
  logic [7:0]  frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SCRAMBLE_ENABLE;
  logic [63:0] cfg_data = 64'h0;

  feed_item_t frame_feed[$];
  result_t    link_bytes_due[$];

  // Scrambler state as the bench sees it.
  bit        scr_on;
  bit [63:0] key_lo;
  bit [63:0] key_hi;
  bit        open_frame;
  bit [3:0]  kidx;
  bit [7:0]  csum;
  bit [7:0]  sent;

  int send_gap_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int errors;
  int quiet;

  keyed_byte_scrambler_frame_unit #(.FRAME_LIMIT(LIMIT)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .is_checksum(is_checksum), .last(last), .frame_length(frame_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic flag(input string what, input int got, input int want);
    $display("ERROR at %0t ns: %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic bit [7:0] key_byte(bit [3:0] idx);
    return idx[3] ? key_hi[idx[2:0] * 8 +: 8] : key_lo[idx[2:0] * 8 +: 8];
  endfunction

  function automatic bit [7:0] scramble(bit [7:0] b, bit [7:0] k);
    bit [7:0] x;
    x = b ^ k;
    x = {x[1:0], x[7:2]};
    return x ^ k;
  endfunction

  function automatic void owe(bit [7:0] b, bit chk, bit fin, bit [7:0] len);
    result_t r;
    r.out_byte = b;
    r.is_checksum = chk;
    r.last = fin;
    r.frame_length = len;
    link_bytes_due.push_back(r);
  endfunction

  function automatic void scramble_item(logic k, logic [7:0] b);
    bit [7:0] s;
    bit fin;
    if (k == KIND_START) begin
      open_frame = 1'b1;
      if (scr_on) begin
        csum = b;
        kidx = b[7:4] + b[3:0];
        sent = 8'd1;
        owe(b, 1'b0, 1'b0, sent);
      end else begin
        csum = 8'h00;
        kidx = 4'd0;
        sent = 8'd0;
      end
      return;
    end
    if (!open_frame) return;
    if (scr_on) begin
      if (b == CR_BYTE) begin
        open_frame = 1'b0;
        owe(csum, 1'b1, 1'b1, 8'(sent + 1));
        return;
      end
      s = scramble(b, key_byte(kidx));
      kidx = kidx + 4'd1;
      csum = csum ^ s;
      sent = sent + 8'd1;
      owe(s, 1'b0, 1'b0, sent);
      if (sent >= LIMIT) begin
        open_frame = 1'b0;
        owe(csum, 1'b1, 1'b1, 8'(sent + 1));
      end
    end else begin
      sent = sent + 8'd1;
      fin = (b == CR_BYTE) || (sent >= LIMIT);
      if (fin) open_frame = 1'b0;
      owe(b, 1'b0, fin, sent);
    end
  endfunction

  function automatic void send(logic k, logic [7:0] b);
    feed_item_t it;
    it.kind = k;
    it.data = b;
    frame_feed.push_back(it);
  endfunction

  // Queues one frame and returns the number of its items up to and including the CR, if any.
  function automatic int queue_frame(bit force_long);
    int len;
    int r;
    int n;
    r = $urandom_range(99);
    len = (force_long || r < 6) ? $urandom_range(135, 150) : $urandom_range(0, 12);
    send(KIND_START, 8'($urandom_range(255)));
    repeat (len) send(KIND_DATA, 8'($urandom_range(255)));
    n = len + 1;
    r = $urandom_range(99);
    if (r < 70) begin
      send(KIND_DATA, CR_BYTE);
      n++;
    end else if (r >= 85) begin
      send(KIND_DATA, CR_BYTE);
      n++;
      repeat ($urandom_range(1, 3)) send(KIND_DATA, 8'($urandom_range(255)));
    end
    return n;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCRAMBLE_ENABLE: scr_on = value[0];
      REG_KEY_LOW:         key_lo = value;
      REG_KEY_HIGH:        key_hi = value;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (frame_feed.size() != 0 || link_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    bit busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        scramble_item(kind, data_byte);
        void'(frame_feed.pop_front());
        busy = 1'b0;
      end
      if (!busy) begin
        if (frame_feed.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          kind <= frame_feed[0].kind;
          data_byte <= frame_feed[0].data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (link_bytes_due.size() == 0) begin
          flag("result with nothing expected", out_byte, 0);
        end else begin
          want = link_bytes_due.pop_front();
          if (out_byte !== want.out_byte) flag("out_byte", out_byte, want.out_byte);
          if (is_checksum !== want.is_checksum)
            flag("is_checksum", is_checksum, want.is_checksum);
          if (last !== want.last) flag("last", last, want.last);
          if (frame_length !== want.frame_length)
            flag("frame_length", frame_length, want.frame_length);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int made;
    int p;
    int mode;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Unit still disabled from reset.
    send(KIND_DATA, 8'hff);
    send(KIND_START, 8'ha5);
    send(KIND_DATA, 8'h00);
    send(KIND_DATA, 8'hff);
    send(KIND_DATA, CR_BYTE);
    send(KIND_DATA, 8'h42);
    settle();
    write_reg(REG_KEY_LOW, 64'h0123456789abcdef);
    write_reg(REG_KEY_HIGH, 64'hfedcba9876543210);
    write_reg(REG_SCRAMBLE_ENABLE, 64'h1);
    send(KIND_START, 8'hff);
    send(KIND_DATA, 8'h00);
    send(KIND_DATA, 8'hff);
    send(KIND_DATA, CR_BYTE);
    send(KIND_START, 8'h00);
    send(KIND_DATA, 8'h80);
    send(KIND_START, 8'h3c);
    send(KIND_DATA, 8'h01);
    send(KIND_DATA, 8'h7f);
    settle();
    // The open frame carries on across enable changes.
    write_reg(REG_SCRAMBLE_ENABLE, 64'h0);
    send(KIND_DATA, 8'h55);
    settle();
    write_reg(REG_SCRAMBLE_ENABLE, 64'h1);
    send(KIND_DATA, 8'haa);
    send(KIND_DATA, CR_BYTE);
    send(KIND_START, 8'h11);
    settle();
    write_reg(REG_SCRAMBLE_ENABLE, 64'h0);
    send(KIND_START, 8'h22);
    send(KIND_DATA, CR_BYTE);
    settle();

    for (p = 0; p < 8; p++) begin
      mode = p % 4;
      if (p == 0) begin
        write_reg(REG_KEY_LOW, 64'h0);
        write_reg(REG_KEY_HIGH, 64'h0);
      end else if (p == 1) begin
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '1);
      end else begin
        write_reg(REG_KEY_LOW, {$urandom, $urandom});
        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
      end
      write_reg(REG_SCRAMBLE_ENABLE, (p % 3 != 2) ? 64'h1 : 64'h0);
      send_gap_pct = (mode == 1) ? 75 : (mode == 3) ? 28 : 0;
      recv_stall_pct = (mode == 2) ? 75 : (mode == 3) ? 28 : 0;
      made = 3;
      repeat (3) send(KIND_DATA, 8'($urandom_range(255)));
      if (p == 1 || p == 2) made += queue_frame(1'b1);
      while (made < 225) made += queue_frame(1'b0);
      send(KIND_START, 8'($urandom_range(255)));
      repeat (3) send(KIND_DATA, 8'($urandom_range(255)));
      if (mode == 0) hold_req = 1'b1;
      settle();
    end

    if (link_bytes_due.size() != 0)
      flag("expected results never arrived", link_bytes_due.size(), 0);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
